[rtl/stm_pkg.sv]
`default_nettype none
package stm_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int SAMPLE_BITS    = 32;
    localparam int WLEN_BITS      = 7;
    localparam int CFG_IDX_BITS   = 8;
    localparam int CFG_DATA_BITS  = 8;
    localparam int ROOT_BITS      = 2 * SAMPLE_BITS;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WINDOW_LENGTH = 8'd0,
        REG_DISCARD       = 8'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVICT,
        ST_WRITE,
        ST_SCAN,
        ST_MDIV,
        ST_MWAIT,
        ST_VAR,
        ST_VDIV,
        ST_VWAIT,
        ST_SQRT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

[rtl/stm_ram.sv]
`default_nettype none
module stm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                            clk,
    input  wire logic                            we,
    input  wire logic [$clog2(DEPTH)-1:0]        waddr,
    input  wire logic [WIDTH-1:0]                wdata,
    input  wire logic [$clog2(DEPTH)-1:0]        raddr,
    output logic      [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

[rtl/stm_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module stm_div #(
    parameter int DIVIDEND_W = 71,
    parameter int DIVISOR_W  = 7
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [DIVIDEND_W-1:0]   dividend,
    input  wire logic [DIVISOR_W-1:0]    divisor,
    output logic      [DIVIDEND_W-1:0]   quotient,
    output stm_pkg::div_stat_t           stat
);

    localparam int NW = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [NW-1:0]         cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = NW'(DIVIDEND_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - NW'(1);
            done_next = (cnt_reg == NW'(1));
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule
`default_nettype wire

[rtl/sliding_trimmed_mean_stddev.sv]
`default_nettype none
// Channel  | Dir | Handshake              | Payload
// s_*      | in  | s_tvalid / s_tready    | s_tdata: sample
// m_*      | out | m_tvalid / m_tready    | m_tdata: mean_value, std_deviation; m_tuser: flag
// cfg_*    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each sample runs a min/max scan (only when trimming) and a variance pass over the ring
// through its single read port, two runs of the bit-serial divider and 32 root steps.
// s_tready is high only between samples; a finished result sits in the output register,
// so a stalled m_tready holds only the final load. Reset empties the window; ring
// contents need no clearing. cfg_ready is high only between samples and wins over a
// waiting sample beat.
module sliding_trimmed_mean_stddev #(
    parameter int WINDOW_MAX = stm_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [31:0]                        s_tdata,   // [31:0] sample
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [63:0]                        m_tdata,   // [31:0] mean_value, [63:32] std_deviation
    output logic      [0:0]                         m_tuser,   // [0] extremes_dropped
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [stm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [stm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int SB   = stm_pkg::SAMPLE_BITS;
    localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW   = $clog2(WINDOW_MAX + 1);
    localparam int SUMW = SB + CW + 1;
    localparam int ACCW = 2 * SB + CW;
    localparam int RB   = stm_pkg::ROOT_BITS;

    stm_pkg::state_t state_reg, state_next;

    logic [stm_pkg::WLEN_BITS-1:0] wlen_reg, wlen_next;
    logic                          disc_reg, disc_next;
    logic [CW-1:0]                 win_eff;

    logic signed [SB-1:0]   x_reg, x_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [AW-1:0]          oldest_reg, oldest_next;
    logic signed [SUMW-1:0] sum_reg, sum_next;
    logic                   trim_reg, trim_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   rdv_reg, rdv_next;
    logic [CW-1:0]          rdpos_reg, rdpos_next;
    logic signed [SB-1:0]   mn_reg, mn_next, mx_reg, mx_next;
    logic [CW-1:0]          mnpos_reg, mnpos_next, mxpos_reg, mxpos_next;
    logic                   neg_reg, neg_next;
    logic [CW-1:0]          dsr_reg, dsr_next;
    logic [SB-1:0]          mean_reg, mean_next;
    logic [SB-1:0]          mag_reg, mag_next;
    logic                   v2_reg, v2_next;
    logic [2*SB-1:0]        sq_reg, sq_next;
    logic                   v3_reg, v3_next;
    logic [ACCW-1:0]        acc_reg, acc_next;
    logic [RB-1:0]          rx_reg, rx_next, res_reg, res_next, bit_reg, bit_next;
    logic                   mv_reg, mv_next;
    logic [63:0]            mdata_reg, mdata_next;
    logic                   muser_reg, muser_next;

    // ring access
    logic [CW-1:0]   offset;
    logic [CW:0]     ring_sum;
    logic [CW:0]     ring_wrap;
    logic [AW-1:0]   ring_addr;
    logic [AW-1:0]   raddr;
    logic            we;
    logic [SB-1:0]   rdata;
    logic signed [SB-1:0] rsample;
    logic [CW:0]     old_inc;

    // arithmetic
    logic signed [SUMW-1:0] num;
    logic [SUMW-1:0]        num_mag;
    logic signed [SB:0]     diff;
    logic [SB:0]            diff_mag;
    logic [RB-1:0]          root_trial;
    logic [SB-1:0]          q_low;
    logic                   skip;

    logic                   div_start;
    logic [ACCW-1:0]        div_dividend;
    logic [ACCW-1:0]        div_quotient;
    stm_pkg::div_stat_t     div_st;

    stm_ram #(
        .WIDTH (SB),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (we),
        .waddr (ring_addr),
        .wdata (x_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    stm_div #(
        .DIVIDEND_W (ACCW),
        .DIVISOR_W  (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dsr_reg),
        .quotient (div_quotient),
        .stat     (div_st)
    );

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            win_eff = CW'(1);
        end
        else if (32'(wlen_reg) > 32'(WINDOW_MAX))
        begin
            win_eff = CW'(WINDOW_MAX);
        end
        else
        begin
            win_eff = CW'(wlen_reg);
        end
    end

    always_comb
    begin
        offset    = (state_reg == stm_pkg::ST_WRITE) ? fill_reg : cnt_reg;
        ring_sum  = (CW+1)'(oldest_reg) + (CW+1)'(offset);
        ring_wrap = ring_sum - (CW+1)'(win_eff);
        ring_addr = (ring_sum >= (CW+1)'(win_eff)) ? ring_wrap[AW-1:0] : ring_sum[AW-1:0];
        raddr     = (state_reg == stm_pkg::ST_IDLE) ? oldest_reg : ring_addr;
        old_inc   = (CW+1)'(oldest_reg) + (CW+1)'(1);
        rsample   = rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= stm_pkg::ST_IDLE;
            wlen_reg   <= stm_pkg::WLEN_RESET;
            disc_reg   <= 1'b0;
            fill_reg   <= '0;
            oldest_reg <= '0;
            sum_reg    <= '0;
            rdv_reg    <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wlen_reg   <= wlen_next;
            disc_reg   <= disc_next;
            fill_reg   <= fill_next;
            oldest_reg <= oldest_next;
            sum_reg    <= sum_next;
            rdv_reg    <= rdv_next;
            v2_reg     <= v2_next;
            v3_reg     <= v3_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        trim_reg  <= trim_next;
        cnt_reg   <= cnt_next;
        rdpos_reg <= rdpos_next;
        mn_reg    <= mn_next;
        mx_reg    <= mx_next;
        mnpos_reg <= mnpos_next;
        mxpos_reg <= mxpos_next;
        neg_reg   <= neg_next;
        dsr_reg   <= dsr_next;
        mean_reg  <= mean_next;
        mag_reg   <= mag_next;
        sq_reg    <= sq_next;
        acc_reg   <= acc_next;
        rx_reg    <= rx_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        wlen_next    = wlen_reg;
        disc_next    = disc_reg;
        x_next       = x_reg;
        fill_next    = fill_reg;
        oldest_next  = oldest_reg;
        sum_next     = sum_reg;
        trim_next    = trim_reg;
        cnt_next     = cnt_reg;
        rdv_next     = 1'b0;
        rdpos_next   = rdpos_reg;
        mn_next      = mn_reg;
        mx_next      = mx_reg;
        mnpos_next   = mnpos_reg;
        mxpos_next   = mxpos_reg;
        neg_next     = neg_reg;
        dsr_next     = dsr_reg;
        mean_next    = mean_reg;
        mag_next     = mag_reg;
        v2_next      = 1'b0;
        sq_next      = sq_reg;
        v3_next      = 1'b0;
        acc_next     = acc_reg;
        rx_next      = rx_reg;
        res_next     = res_reg;
        bit_next     = bit_reg;
        mv_next      = mv_reg;
        mdata_next   = mdata_reg;
        muser_next   = muser_reg;
        we           = 1'b0;
        div_start    = 1'b0;

        num          = sum_reg - (trim_reg ? (SUMW'(mn_reg) + SUMW'(mx_reg)) : '0);
        num_mag      = num[SUMW-1] ? $unsigned(-num) : $unsigned(num);
        div_dividend = (state_reg == stm_pkg::ST_MDIV) ? ACCW'(num_mag) : acc_reg;
        q_low        = div_quotient[SB-1:0];
        diff         = (SB+1)'(rsample) - (SB+1)'($signed(mean_reg));
        diff_mag     = diff[SB] ? $unsigned(-diff) : $unsigned(diff);
        root_trial   = res_reg + bit_reg;
        skip         = trim_reg && ((cnt_reg == mnpos_reg) || (cnt_reg == mxpos_reg));

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                stm_pkg::REG_WINDOW_LENGTH:
                begin
                    wlen_next   = cfg_data[stm_pkg::WLEN_BITS-1:0];
                    fill_next   = '0;
                    oldest_next = '0;
                    sum_next    = '0;
                end
                stm_pkg::REG_DISCARD:
                begin
                    disc_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            stm_pkg::ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    x_next     = s_tdata;
                    state_next = (fill_reg >= win_eff) ? stm_pkg::ST_EVICT
                                                      : stm_pkg::ST_WRITE;
                end
            end
            stm_pkg::ST_EVICT:
            begin
                // drop the oldest sample
                sum_next    = sum_reg - SUMW'(rsample);
                oldest_next = (old_inc == (CW+1)'(win_eff)) ? '0 : old_inc[AW-1:0];
                fill_next   = fill_reg - CW'(1);
                state_next  = stm_pkg::ST_WRITE;
            end
            stm_pkg::ST_WRITE:
            begin
                we         = 1'b1;
                sum_next   = sum_reg + SUMW'(x_reg);
                fill_next  = fill_reg + CW'(1);
                trim_next  = disc_reg && (fill_reg >= CW'(2));
                // divisor for both divides: the new count, less two when trimming
                dsr_next   = (disc_reg && (fill_reg >= CW'(2))) ? (fill_reg - CW'(1))
                                                               : (fill_reg + CW'(1));
                cnt_next   = '0;
                state_next = (disc_reg && (fill_reg >= CW'(2))) ? stm_pkg::ST_SCAN
                                                               : stm_pkg::ST_MDIV;
            end
            stm_pkg::ST_SCAN:
            begin
                if (cnt_reg < fill_reg)
                begin
                    rdv_next   = 1'b1;
                    rdpos_next = cnt_reg;
                    cnt_next   = cnt_reg + CW'(1);
                end
                // strict compares keep the oldest of equal extremes
                if (rdv_reg)
                begin
                    if ((rdpos_reg == '0) || (rsample < mn_reg))
                    begin
                        mn_next    = rsample;
                        mnpos_next = rdpos_reg;
                    end
                    if ((rdpos_reg == '0) || (rsample > mx_reg))
                    begin
                        mx_next    = rsample;
                        mxpos_next = rdpos_reg;
                    end
                end
                if ((cnt_reg == fill_reg) && !rdv_reg)
                begin
                    state_next = stm_pkg::ST_MDIV;
                end
            end
            stm_pkg::ST_MDIV:
            begin
                div_start  = 1'b1;
                neg_next   = num[SUMW-1];
                state_next = stm_pkg::ST_MWAIT;
            end
            stm_pkg::ST_MWAIT:
            begin
                if (div_st.done)
                begin
                    mean_next  = neg_reg ? (-q_low) : q_low;
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = stm_pkg::ST_VAR;
                end
            end
            stm_pkg::ST_VAR:
            begin
                if (cnt_reg < fill_reg)
                begin
                    rdv_next = !skip;
                    cnt_next = cnt_reg + CW'(1);
                end
                if (rdv_reg)
                begin
                    mag_next = diff_mag[SB-1:0];
                    v2_next  = 1'b1;
                end
                if (v2_reg)
                begin
                    sq_next = mag_reg * mag_reg;
                    v3_next = 1'b1;
                end
                if (v3_reg)
                begin
                    acc_next = acc_reg + ACCW'(sq_reg);
                end
                if ((cnt_reg == fill_reg) && !rdv_reg && !v2_reg && !v3_reg)
                begin
                    state_next = stm_pkg::ST_VDIV;
                end
            end
            stm_pkg::ST_VDIV:
            begin
                div_start  = 1'b1;
                state_next = stm_pkg::ST_VWAIT;
            end
            stm_pkg::ST_VWAIT:
            begin
                if (div_st.done)
                begin
                    rx_next    = div_quotient[RB-1:0];
                    res_next   = '0;
                    bit_next   = RB'(1) << (RB - 2);
                    state_next = stm_pkg::ST_SQRT;
                end
            end
            stm_pkg::ST_SQRT:
            begin
                if (rx_reg >= root_trial)
                begin
                    rx_next  = rx_reg - root_trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == RB'(1))
                begin
                    state_next = stm_pkg::ST_DONE;
                end
            end
            stm_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    mdata_next = {res_reg[31:0], mean_reg};
                    muser_next = trim_reg;
                    state_next = stm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stm_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready  = (state_reg == stm_pkg::ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == stm_pkg::ST_IDLE);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = mdata_reg;
    assign m_tuser   = muser_reg;

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= win_eff)
        else $error("fill count beyond window");

    assert property (@(posedge clk) disable iff (!rst_n)
        (CW+1)'(oldest_reg) < (CW+1)'(win_eff))
        else $error("oldest slot outside window");

    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !div_st.busy)
        else $error("divider busy while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == stm_pkg::ST_DONE))
        else $error("result raised outside done state");

endmodule
`default_nettype wire
